@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define SPT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define SPT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/spt_pkg.sv @@
package spt_pkg;

  // field widths
  localparam int unsigned PN_W     = 62;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned SIDX_W   = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 7;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned FLIGHT_W = 22;
  localparam int unsigned CMD_W    = 2;

  // input tdata layout
  localparam int unsigned PN_LSB    = 0;
  localparam int unsigned TIME_LSB  = PN_LSB + PN_W;
  localparam int unsigned ACK_BIT   = TIME_LSB + TIME_W;
  localparam int unsigned FLT_BIT   = ACK_BIT + 1;
  localparam int unsigned SIZE_LSB  = FLT_BIT + 1;
  localparam int unsigned SIDX_LSB  = SIZE_LSB + SIZE_W;
  localparam int unsigned IN_RAW_W  = SIDX_LSB + SIDX_W;
  localparam int unsigned IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8;
  localparam int unsigned IN_USER_W = CMD_W;

  // output tdata layout
  localparam int unsigned OUT_RAW_W  = SLOT_W + COUNT_W + FLIGHT_W;
  localparam int unsigned OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - OUT_RAW_W;
  localparam int unsigned OUT_USER_W = STATUS_W;

  // command codes on the bus
  localparam logic [CMD_W-1:0] CMD_RECORD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RECLAIM = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND    = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REFUSED   = 2'd3;

  typedef enum logic [1:0] {
    OP_RECORD,
    OP_RECLAIM,
    OP_FIND,
    OP_NOP
  } op_e;

  // one decoded command as it sits in the queue
  typedef struct packed {
    op_e               op;
    logic [PN_W-1:0]   pn;
    logic              flt;
    logic [SIZE_W-1:0] size;
    logic [SIDX_W-1:0] sidx;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  count;
    logic [FLIGHT_W-1:0] flight;
  } result_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic valid;
  } qstat_t;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // slots per group of the lowest-set search
  localparam int unsigned GROUP_LANES = 16;
  localparam int unsigned GLANE_W     = $clog2(GROUP_LANES);

endpackage

@@ rtl/spt_front.sv @@
module spt_front (
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [spt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic [spt_pkg::IN_USER_W-1:0]   s_axis_tuser,
  input  spt_pkg::qstat_t                 qstat_i,
  output logic                            push_o,
  output spt_pkg::item_t                  item_o
);
  import spt_pkg::*;

  op_e op;

  always_comb begin
    unique case (s_axis_tuser)
      CMD_RECORD:  op = OP_RECORD;
      CMD_RECLAIM: op = OP_RECLAIM;
      CMD_FIND:    op = OP_FIND;
      default:     op = OP_NOP;
    endcase
  end

  // send time and ack flag are never read back, so not kept
  always_comb begin
    item_o.op   = op;
    item_o.pn   = s_axis_tdata[PN_LSB +: PN_W];
    item_o.flt  = s_axis_tdata[FLT_BIT];
    item_o.size = s_axis_tdata[SIZE_LSB +: SIZE_W];
    item_o.sidx = s_axis_tdata[SIDX_LSB +: SIDX_W];
  end

  assign s_axis_tready = !qstat_i.full;
  assign push_o        = s_axis_tvalid && !qstat_i.full;

endmodule

@@ rtl/spt_queue.sv @@
module spt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  spt_pkg::item_t  item_i,
  input  logic            pop_i,
  output spt_pkg::qstat_t qstat_o,
  output spt_pkg::item_t  item_o
);
  import spt_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;

  // depth is a power of two: pointers wrap by themselves
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o        = mem_q[rd_ptr_q];
  assign qstat_o.valid = (cnt_q != '0);
  assign qstat_o.full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));

endmodule

@@ rtl/spt_back.sv @@
module spt_back #(
  parameter int unsigned TABLE_SLOTS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  spt_pkg::qstat_t  qstat_i,
  input  spt_pkg::item_t   item_i,
  output logic             pop_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output spt_pkg::result_t res_o
);
  import spt_pkg::*;

  localparam int unsigned IDX_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned TOT_W  = $clog2(TABLE_SLOTS * ((2 ** SIZE_W) - 1) + 1);
  localparam int unsigned NGRP   = (TABLE_SLOTS + GROUP_LANES - 1) / GROUP_LANES;
  localparam int unsigned GIDX_W = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int unsigned PAD_W  = NGRP * GROUP_LANES;
  localparam int unsigned POS_W  = GIDX_W + GLANE_W;

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_SCAN    = 2'd1;
  localparam logic [1:0] S_GROUP   = 2'd2;
  localparam logic [1:0] S_RESOLVE = 2'd3;

  logic [1:0]             state_q, state_d;
  item_t                  op_q;
  logic [TABLE_SLOTS-1:0] used_q, used_d;
  logic [PN_W-1:0]        num_q [TABLE_SLOTS];
  logic [SIZE_W:0]        attr_mem [TABLE_SLOTS];
  logic [SIZE_W:0]        attr_rd_q;
  logic [PAD_W-1:0]       hit_q, hit_d;
  logic [NGRP-1:0]        grp_any_q, grp_any_d;
  logic [GLANE_W-1:0]     grp_low_q [NGRP];
  logic [GLANE_W-1:0]     grp_low_d [NGRP];
  logic [CNT_W-1:0]       entries_q, entries_d;
  logic [TOT_W-1:0]       total_q, total_d;
  logic                   res_valid_q, res_valid_d;
  result_t                res_q;

  logic                   found;
  logic [POS_W-1:0]       pos;
  logic [IDX_W-1:0]       hit_slot;
  logic [IDX_W-1:0]       rec_idx;
  logic                   in_range;
  logic                   reclaim_ok;
  logic                   commit;
  logic                   store_we;
  logic [STATUS_W-1:0]    status;
  logic [CNT_W-1:0]       slot_c;

  // parallel compare: free slots for record, matching used slots for find
  always_comb begin
    hit_d = '0;
    for (int k = 0; k < TABLE_SLOTS; k++) begin
      case (op_q.op)
        OP_RECORD: hit_d[k] = !used_q[k];
        OP_FIND:   hit_d[k] = used_q[k] && (num_q[k] == op_q.pn);
        default:   hit_d[k] = 1'b0;
      endcase
    end
  end

  // first level: lowest hit inside each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_d[g] = |hit_q[g*GROUP_LANES +: GROUP_LANES];
      grp_low_d[g] = '0;
      for (int j = GROUP_LANES - 1; j >= 0; j--) begin
        if (hit_q[g*GROUP_LANES + j]) begin
          grp_low_d[g] = GLANE_W'(j);
        end
      end
    end
  end

  // second level: lowest group with a hit
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        found = 1'b1;
        pos   = {GIDX_W'(g), grp_low_q[g]};
      end
    end
    hit_slot = IDX_W'(pos);
  end

  assign rec_idx    = IDX_W'(op_q.sidx);
  assign in_range   = (32'(op_q.sidx) < 32'(TABLE_SLOTS));
  assign reclaim_ok = in_range && used_q[rec_idx];
  assign commit     = (state_q == S_RESOLVE) && (!res_valid_q || res_ready_i);

  always_comb begin
    status    = ST_DONE;
    slot_c    = CNT_W'(TABLE_SLOTS);
    entries_d = entries_q;
    total_d   = total_q;
    used_d    = used_q;
    store_we  = 1'b0;
    case (op_q.op)
      OP_RECORD: begin
        if (found) begin
          slot_c    = CNT_W'(hit_slot);
          entries_d = entries_q + CNT_W'(1);
          if (op_q.flt) begin
            total_d = total_q + TOT_W'(op_q.size);
          end
          used_d[hit_slot] = 1'b1;
          store_we         = commit;
        end else begin
          status = ST_FULL;
        end
      end
      OP_RECLAIM: begin
        if (reclaim_ok) begin
          slot_c    = CNT_W'(rec_idx);
          entries_d = entries_q - CNT_W'(1);
          if (attr_rd_q[SIZE_W]) begin
            total_d = total_q - TOT_W'(attr_rd_q[SIZE_W-1:0]);
          end
          used_d[rec_idx] = 1'b0;
        end else begin
          status = ST_REFUSED;
        end
      end
      OP_FIND: begin
        if (found) begin
          slot_c = CNT_W'(hit_slot);
        end else begin
          status = ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (qstat_i.valid) state_d = S_SCAN;
      S_SCAN:    state_d = S_GROUP;
      S_GROUP:   state_d = S_RESOLVE;
      S_RESOLVE: if (commit) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  assign pop_o       = (state_q == S_IDLE) && qstat_i.valid;
  assign res_valid_d = commit ? 1'b1 : (res_ready_i ? 1'b0 : res_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      entries_q   <= '0;
      total_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (commit) begin
        used_q    <= used_d;
        entries_q <= entries_d;
        total_q   <= total_d;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      op_q <= item_i;
    end
    if (state_q == S_SCAN) begin
      hit_q <= hit_d;
    end
    if (state_q == S_GROUP) begin
      grp_any_q <= grp_any_d;
      grp_low_q <= grp_low_d;
    end
    if (commit) begin
      res_q.status <= status;
      res_q.slot   <= SLOT_W'(slot_c);
      res_q.count  <= COUNT_W'(entries_d);
      res_q.flight <= FLIGHT_W'(total_d);
    end
  end

  // packet number store: one compare per slot
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      num_q[hit_slot] <= op_q.pn;
    end
  end

  // size and in-flight flag: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      attr_mem[hit_slot] <= {op_q.flt, op_q.size};
    end
    attr_rd_q <= attr_mem[rec_idx];
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ rtl/sent_packet_table.sv @@
// channel  | dir | handshake                      | payload
// ---------+-----+--------------------------------+---------------------------------------
// command  | in  | s_axis_tvalid / s_axis_tready  | tuser: cmd; tdata: see port list
// result   | out | m_axis_tvalid / m_axis_tready  | tuser: status; tdata: see port list
//
// Each command passes queue pop, parallel compare over all slots, lowest hit per group of 16
// slots, then pick of the lowest group with the table update and result load.
// The front takes commands into a two-deep queue while the back is busy or its result waits.
// Reset clears the used map, entry count, in-flight total, queue and handshakes at once.
// A held result stalls the back in its last step; the queue keeps taking transfers until full.
`include "assert_macros.svh"

module sent_packet_table #(
  parameter int unsigned TABLE_SLOTS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // packet_number, send_time, ack flag, flight flag, packet_bytes, slot_index, pad
  input  logic [spt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // cmd
  input  logic [spt_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // slot, entry_count, bytes_in_flight, pad
  output logic [spt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // status
  output logic [spt_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
  import spt_pkg::*;

  // most transfers held at once: queue, back, result register
  localparam int unsigned OUTST_MAX = QUEUE_DEPTH + 2;
  localparam int unsigned OUTST_W   = $clog2(OUTST_MAX + 1);

  qstat_t  qstat;
  logic    push;
  logic    pop;
  item_t   front_item;
  item_t   head_item;
  result_t res;

  spt_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .qstat_i       (qstat),
    .push_o        (push),
    .item_o        (front_item)
  );

  spt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .qstat_o (qstat),
    .item_o  (head_item)
  );

  spt_back #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .item_i      (head_item),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {OUT_PAD_W'(0), res.flight, res.count, res.slot};
  assign m_axis_tuser = res.status;

  // transfers taken but not yet delivered
  logic               in_xfer;
  logic               out_xfer;
  logic [OUTST_W-1:0] outst_q, outst_d;
  logic               res_full;
  logic               res_failed;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign outst_d  = outst_q + OUTST_W'(in_xfer) - OUTST_W'(out_xfer);

  // any status but done carries no slot
  assign res_full   = m_axis_tvalid && (res.status == ST_FULL);
  assign res_failed = m_axis_tvalid && (res.status != ST_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else begin
      outst_q <= outst_d;
    end
  end

  `SPT_ASSERT(a_outst_bound, clk_i, rst_ni, outst_q <= OUTST_W'(OUTST_MAX), "too many held")
  `SPT_ASSERT_IMP(a_no_phantom, clk_i, rst_ni, m_axis_tvalid, outst_q != '0, "result from nothing")
  `SPT_ASSERT_IMP(a_full_count, clk_i, rst_ni, res_full, res.count == COUNT_W'(TABLE_SLOTS),
                  "full with free slot")
  `SPT_ASSERT_IMP(a_fail_slot, clk_i, rst_ni, res_failed, res.slot == SLOT_W'(TABLE_SLOTS),
                  "failed with slot")

endmodule
